/* sv/point_to_triangle_coordinates_macros.svh */
// Assertion macros shared by the point-to-triangle coordinate block.
`ifndef POINT_TO_TRIANGLE_COORDINATES_MACROS_SVH
`define POINT_TO_TRIANGLE_COORDINATES_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition c holds in the same cycle as a.
`define PTC_ASSERT_SAME(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
    else $error("ptc check failed");

// Condition c holds in the cycle after a.
`define PTC_ASSERT_NEXT(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("ptc check failed");

`else

`define PTC_ASSERT_SAME(lbl, clk, rstn, a, c)
`define PTC_ASSERT_NEXT(lbl, clk, a, c)

`endif

`endif

/* sv/ptc_pkg.sv */
// Types and constants for the point-to-triangle coordinate block.
package ptc_pkg;

  localparam int COORD_W = 24;
  localparam int RES_W   = 32;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] edge_end_a_x;
    logic signed [COORD_W-1:0] edge_end_a_y;
    logic signed [COORD_W-1:0] edge_end_a_z;
    logic signed [COORD_W-1:0] edge_end_b_x;
    logic signed [COORD_W-1:0] edge_end_b_y;
    logic signed [COORD_W-1:0] edge_end_b_z;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } in_word_t;

  typedef struct packed {
    logic signed [RES_W-1:0] coord_u;
    logic signed [RES_W-1:0] coord_v;
    logic                    degenerate;
  } out_word_t;

endpackage

/* sv/point_to_triangle_coordinates.sv */
// Pipelined projection of a 3D point onto the edge coordinates of a triangle.
//
// Usage: each input word carries a triangle (origin and two further vertices)
// and a query point, all signed fixed point. Each accepted word yields exactly
// one output word holding the coordinates u and v in signed fixed point with
// OUT_FRAC_BITS fraction bits, saturated to 32 bits, and a degenerate flag.
// A word is taken on a rising edge with valid high and stall low.
// Throughput: one word per clock while the output is not stalled. Eight
// stages form the edge vectors, dot products, split wide products and the
// determinant; the two divisions then run as restoring dividers with one
// quotient bit per stage, 32 stages.
// When the output is valid and stalled, the whole pipeline holds and in_stall
// is raised, so nothing is lost or repeated. Bubbles travel as invalid stages.
// Reset clears every valid bit; the data registers are not reset.
// A triangle with zero determinant gives zero coordinates and degenerate set.
`include "point_to_triangle_coordinates_macros.svh"

module point_to_triangle_coordinates
  import ptc_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int DW  = COORD_W + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 2;
  localparam int MW  = SW;
  localparam int H   = (MW + 1) / 2;
  localparam int PRW = 4 * H;
  localparam int NW  = PRW + 2;
  localparam int QW  = RES_W;
  localparam int XW  = NW + OUT_FRAC_BITS;
  localparam int HIW = XW - QW;

  localparam int OPX [6] = '{0, 2, 3, 4, 4, 3};
  localparam int OPY [6] = '{1, 2, 1, 2, 0, 2};

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [QW-1:0] lo;
    logic [QW-1:0] q;
    logic          neg;
    logic          ovf;
  } lane_t;

  typedef struct packed {
    logic [NW-1:0] det;
    logic          dz;
  } dcom_t;

  logic adv;

  logic                 v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;
  logic signed [DW-1:0] a_r [3], b_r [3], d_r [3];
  logic signed [PW-1:0] paa_r [3], pbb_r [3], pab_r [3], pad_r [3], pbd_r [3];
  logic signed [SW-1:0] dt_r [5];
  logic [MW-1:0]        mg_r [5];
  logic                 sg_r [5];
  logic [2*H-1:0]       pp_r [6][4];
  logic                 ps_r [6];
  logic [PRW-1:0]       pr_r [6];
  logic                 ps6_r [6];
  logic signed [NW-1:0] det7_r, nu7_r, nv7_r;
  logic [NW-1:0]        det8_r, mu8_r, mv8_r;
  logic                 dz8_r, nu8_neg_r, nv8_neg_r;

  lane_t                du_r [QW+1];
  lane_t                dv_r [QW+1];
  dcom_t                dc_r [QW+1];
  logic                 vd_r [QW+1];

  out_word_t            out_r;
  logic                 out_valid_r;

  logic signed [COORD_W-1:0] ov [3], pv [3], qv [3], sv [3];
  logic signed [NW-1:0]      sp [6];
  logic [XW-1:0]             xu, xv;
  logic [HIW-1:0]            hu, hv;
  logic                      ou, ovv;
  lane_t                     du_nxt [QW+1];
  lane_t                     dv_nxt [QW+1];
  out_word_t                 out_nxt;

  function automatic lane_t div_step(lane_t x, logic [NW-1:0] det);
    logic [NW:0] rem2;
    lane_t       y;
    rem2 = {x.rem, x.lo[QW-1]};
    y    = x;
    y.lo = {x.lo[QW-2:0], 1'b0};
    if (rem2 >= {1'b0, det}) begin
      y.rem = NW'(rem2 - {1'b0, det});
      y.q   = {x.q[QW-2:0], 1'b1};
    end else begin
      y.rem = rem2[NW-1:0];
      y.q   = {x.q[QW-2:0], 1'b0};
    end
    return y;
  endfunction

  function automatic logic [QW-1:0] finish(lane_t x);
    logic [QW:0]   lim;
    logic [QW-1:0] r;
    lim = x.neg ? {1'b0, 1'b1, {(QW-1){1'b0}}} : {2'b00, {(QW-1){1'b1}}};
    if (x.ovf || ({1'b0, x.q} > lim)) begin
      r = lim[QW-1:0];
    end else if (x.neg) begin
      r = QW'(-x.q);
    end else begin
      r = x.q;
    end
    return r;
  endfunction

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_comb begin
    ov = '{in_word.origin_x, in_word.origin_y, in_word.origin_z};
    pv = '{in_word.edge_end_a_x, in_word.edge_end_a_y, in_word.edge_end_a_z};
    qv = '{in_word.edge_end_b_x, in_word.edge_end_b_y, in_word.edge_end_b_z};
    sv = '{in_word.point_x, in_word.point_y, in_word.point_z};
  end

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      sp[j] = ps6_r[j] ? -$signed(NW'(pr_r[j])) : $signed(NW'(pr_r[j]));
    end
  end

  always_comb begin
    xu  = XW'(mu8_r) << OUT_FRAC_BITS;
    xv  = XW'(mv8_r) << OUT_FRAC_BITS;
    hu  = xu[XW-1:QW];
    hv  = xv[XW-1:QW];
    ou  = NW'(hu) >= det8_r;
    ovv = NW'(hv) >= det8_r;
    du_nxt[0] = '{rem: ou ? '0 : NW'(hu), lo: xu[QW-1:0], q: '0,
                  neg: nu8_neg_r, ovf: ou};
    dv_nxt[0] = '{rem: ovv ? '0 : NW'(hv), lo: xv[QW-1:0], q: '0,
                  neg: nv8_neg_r, ovf: ovv};
    for (int k = 1; k <= QW; k++) begin
      du_nxt[k] = div_step(du_r[k-1], dc_r[k-1].det);
      dv_nxt[k] = div_step(dv_r[k-1], dc_r[k-1].det);
    end
    if (dc_r[QW].dz) begin
      out_nxt = '{coord_u: '0, coord_v: '0, degenerate: 1'b1};
    end else begin
      out_nxt = '{coord_u: finish(du_r[QW]), coord_v: finish(dv_r[QW]),
                  degenerate: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      for (int k = 0; k <= QW; k++) begin
        vd_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
      vd_r[0] <= v8_r;
      for (int k = 1; k <= QW; k++) begin
        vd_r[k] <= vd_r[k-1];
      end
      out_valid_r <= vd_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_r[i] <= DW'(pv[i]) - DW'(ov[i]);
        b_r[i] <= DW'(qv[i]) - DW'(ov[i]);
        d_r[i] <= DW'(sv[i]) - DW'(ov[i]);
        paa_r[i] <= PW'(a_r[i]) * PW'(a_r[i]);
        pbb_r[i] <= PW'(b_r[i]) * PW'(b_r[i]);
        pab_r[i] <= PW'(a_r[i]) * PW'(b_r[i]);
        pad_r[i] <= PW'(a_r[i]) * PW'(d_r[i]);
        pbd_r[i] <= PW'(b_r[i]) * PW'(d_r[i]);
      end
      dt_r[0] <= SW'(paa_r[0]) + SW'(paa_r[1]) + SW'(paa_r[2]);
      dt_r[1] <= SW'(pbb_r[0]) + SW'(pbb_r[1]) + SW'(pbb_r[2]);
      dt_r[2] <= SW'(pab_r[0]) + SW'(pab_r[1]) + SW'(pab_r[2]);
      dt_r[3] <= SW'(pad_r[0]) + SW'(pad_r[1]) + SW'(pad_r[2]);
      dt_r[4] <= SW'(pbd_r[0]) + SW'(pbd_r[1]) + SW'(pbd_r[2]);
      for (int k = 0; k < 5; k++) begin
        sg_r[k] <= dt_r[k][SW-1];
        mg_r[k] <= dt_r[k][SW-1] ? MW'(-dt_r[k]) : MW'(dt_r[k]);
      end
      for (int j = 0; j < 6; j++) begin
        pp_r[j][0] <= (2*H)'(mg_r[OPX[j]][H-1:0]) * (2*H)'(mg_r[OPY[j]][H-1:0]);
        pp_r[j][1] <= (2*H)'(mg_r[OPX[j]][H-1:0])
                      * (2*H)'((2*H)'(mg_r[OPY[j]]) >> H);
        pp_r[j][2] <= (2*H)'((2*H)'(mg_r[OPX[j]]) >> H)
                      * (2*H)'(mg_r[OPY[j]][H-1:0]);
        pp_r[j][3] <= (2*H)'((2*H)'(mg_r[OPX[j]]) >> H)
                      * (2*H)'((2*H)'(mg_r[OPY[j]]) >> H);
        ps_r[j]    <= sg_r[OPX[j]] ^ sg_r[OPY[j]];
        pr_r[j]    <= PRW'(pp_r[j][0]) + (PRW'(pp_r[j][1]) << H)
                      + (PRW'(pp_r[j][2]) << H) + (PRW'(pp_r[j][3]) << (2*H));
        ps6_r[j]   <= ps_r[j];
      end
      det7_r <= sp[0] - sp[1];
      nu7_r  <= sp[2] - sp[3];
      nv7_r  <= sp[4] - sp[5];
      det8_r     <= det7_r;
      dz8_r      <= det7_r == '0;
      nu8_neg_r  <= nu7_r[NW-1];
      nv8_neg_r  <= nv7_r[NW-1];
      mu8_r      <= nu7_r[NW-1] ? NW'(-nu7_r) : NW'(nu7_r);
      mv8_r      <= nv7_r[NW-1] ? NW'(-nv7_r) : NW'(nv7_r);
      dc_r[0]    <= '{det: det8_r, dz: dz8_r};
      for (int k = 0; k <= QW; k++) begin
        du_r[k] <= du_nxt[k];
        dv_r[k] <= dv_nxt[k];
      end
      for (int k = 1; k <= QW; k++) begin
        dc_r[k] <= dc_r[k-1];
      end
      out_r <= out_nxt;
    end
  end

  `PTC_ASSERT_SAME(a_degen_zero, clk, rst_n, out_valid_r && out_r.degenerate,
                   out_r.coord_u == '0 && out_r.coord_v == '0)
  `PTC_ASSERT_SAME(a_take_fills, clk, rst_n, in_valid && !in_stall, adv)
  `PTC_ASSERT_NEXT(a_reset_empty, clk, !rst_n, !out_valid_r && !v1_r)

endmodule
